// ----- rtl/ssc_pkg.sv -----
// Shared types, codes and commutation tables for the six-step commutation controller.
// No dependencies; imported by ssc_drive_decode and six_step_commutation_controller.

package ssc_pkg;

   // Configuration registers are all ten bits wide.
   localparam int CSR_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STARTUP_STEPS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_STEP     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_MAX      = 2'd2;

   // Configuration reset values.
   localparam logic [CSR_WIDTH-1:0] STARTUP_STEPS_RESET = 10'd199;
   localparam logic [CSR_WIDTH-1:0] DUTY_STEP_RESET     = 10'd100;
   localparam logic [CSR_WIDTH-1:0] DUTY_MAX_RESET      = 10'd999;

   // Duty after reset, before truncation to the duty width.
   localparam int DUTY_RESET = 899;

   // Input event kinds.
   typedef enum logic [1:0] {
      CMD_HOST    = 2'd0,
      CMD_EDGE    = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_CAPTURE = 2'd3
   } command_type;

   // Host command characters.
   localparam logic [7:0] HOST_STOP      = 8'h30;
   localparam logic [7:0] HOST_RUN_CW    = 8'h31;
   localparam logic [7:0] HOST_RUN_CCW   = 8'h32;
   localparam logic [7:0] HOST_DUTY_UP   = 8'h33;
   localparam logic [7:0] HOST_DUTY_DOWN = 8'h34;

   // Back-EMF sense lines that advance the step.
   localparam logic [3:0] SENSE_FIRST = 4'd8;
   localparam logic [3:0] SENSE_LAST  = 4'd10;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } direction_type;

   // Step codes: 0 means drive off, 1 to 6 are the commutation steps.
   localparam logic [2:0] STEP_OFF   = 3'd0;
   localparam logic [2:0] STEP_FIRST = 3'd1;
   localparam logic [2:0] STEP_LAST  = 3'd6;
   localparam logic [2:0] STEP_MIRROR = 3'd7;

   // Phase drive for one step: bit 0 is phase A, bit 1 B, bit 2 C.
   typedef struct packed {
      logic [2:0] high_on;
      logic [2:0] low_level;
   } phase_drive_type;

   // High-side enables per pattern; entry 7 is never selected and mirrors off.
   localparam logic [2:0] HIGH_TAB [8] = '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd4, 3'd0};
   // Low-side pin levels per pattern (0 = switch conducting).
   localparam logic [2:0] LOW_TAB  [8] = '{3'd7, 3'd5, 3'd3, 3'd3, 3'd6, 3'd6, 3'd5, 3'd7};

   function automatic logic [2:0] next_step(input logic [2:0] s);
      next_step = (s >= STEP_LAST) ? STEP_FIRST : s + 3'd1;
   endfunction

endpackage

// ----- rtl/ssc_drive_decode.sv -----
// Maps the driven step and rotation direction onto the six gate-drive levels.
// Depends on ssc_pkg.

module ssc_drive_decode (
   input  logic [2:0]              drive,
   input  ssc_pkg::direction_type  direction,
   output ssc_pkg::phase_drive_type phase
);
   import ssc_pkg::*;

   logic [2:0] pattern;

   always_comb begin
      pattern = (drive > STEP_LAST) ? STEP_OFF : drive;
      // mirror the sequence for counter-clockwise rotation
      if (pattern != STEP_OFF && direction == DIR_CCW) begin
         pattern = STEP_MIRROR - pattern;
      end
      phase.high_on   = HIGH_TAB[pattern];
      phase.low_level = LOW_TAB[pattern];
   end

endmodule

// ----- rtl/six_step_commutation_controller.sv -----
// Top level of the six-step commutation controller: event handling, state and handshake.
// Depends on ssc_pkg and ssc_drive_decode.
//
// Usage:
//  - req_ channel carries one event beat: a host command byte, a back-EMF edge, a startup
//    tick or a timer capture, selected by req_command.
//  - rsp_ channel returns exactly one beat per event: the six phase drive levels, the duty,
//    the commutation step, the run and started flags and the last capture period.
//  - csr_ port writes startup_steps, duty_step and duty_max; write only while idle.
// Timing:
//  - A beat accepted on req goes into the input register, where the state update and pattern
//    lookup happen, and then into the result register, which drives rsp valid.
//  - Throughput is one beat per cycle while rsp_ready is high; the state loop is combinational,
//    so each event sees the state left by the one before it.
// Reset (synchronous, active high): motor stopped, step 1, drive off, duty 899 (truncated
//    to DUTY_WIDTH), period and previous capture 0, registers at 199 / 100 / 999.
// Back-pressure: when rsp_ready is low the result register holds its beat; the input
//    register still takes one more beat, then req_ready drops until the result moves on.

module six_step_commutation_controller #(
   parameter int CAPTURE_WIDTH = 16,
   parameter int DUTY_WIDTH    = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // event channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [7:0]                        req_host_byte,
   input  logic [3:0]                        req_sense_line,
   input  logic [CAPTURE_WIDTH-1:0]          req_capture_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_high_a_on,
   output logic                              rsp_high_b_on,
   output logic                              rsp_high_c_on,
   output logic                              rsp_low_a_level,
   output logic                              rsp_low_b_level,
   output logic                              rsp_low_c_level,
   output logic [DUTY_WIDTH-1:0]             rsp_duty_out,
   output logic [2:0]                        rsp_step_out,
   output logic                              rsp_running_out,
   output logic                              rsp_started_out,
   output logic [CAPTURE_WIDTH:0]            rsp_period_out,
   // configuration
   input  logic                              csr_write_en,
   input  logic [ssc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ssc_pkg::CSR_WIDTH-1:0]     csr_wdata
);
   import ssc_pkg::*;

   localparam int SUM_WIDTH = ((DUTY_WIDTH > CSR_WIDTH) ? DUTY_WIDTH : CSR_WIDTH) + 1;
   localparam int PERIOD_WIDTH = CAPTURE_WIDTH + 1;
   localparam logic [PERIOD_WIDTH-1:0] CAP_MASK = {1'b0, {CAPTURE_WIDTH{1'b1}}};

   // configuration registers
   logic [CSR_WIDTH-1:0] startup_steps_ff, duty_step_ff, duty_max_ff;

   // input register
   logic                     in_valid_ff;
   command_type              in_command_ff;
   logic [7:0]               in_host_byte_ff;
   logic [3:0]               in_sense_line_ff;
   logic [CAPTURE_WIDTH-1:0] in_capture_ff;

   // controller state
   logic [2:0]               step_ff, step_in;
   logic                     running_ff, running_in;
   direction_type            direction_ff, direction_in;
   logic                     started_ff, started_in;
   logic [CSR_WIDTH-1:0]     startup_left_ff, startup_left_in;
   logic [DUTY_WIDTH-1:0]    duty_ff, duty_in;
   logic [CAPTURE_WIDTH-1:0] prev_capture_ff, prev_capture_in;
   logic [PERIOD_WIDTH-1:0]  period_ff, period_in;
   logic [2:0]               drive_ff, drive_in;

   // result register
   logic                     out_valid_ff;
   phase_drive_type          out_phase_ff;
   logic [DUTY_WIDTH-1:0]    out_duty_ff;
   logic [2:0]               out_step_ff;
   logic                     out_running_ff;
   logic                     out_started_ff;
   logic [PERIOD_WIDTH-1:0]  out_period_ff;

   phase_drive_type          phase;
   logic                     advance;
   logic [SUM_WIDTH-1:0]     duty_wide, step_wide, max_wide, duty_sum;
   logic [CSR_WIDTH-1:0]     left_dec;

   // Move the held beat into the result register when that register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         startup_steps_ff <= STARTUP_STEPS_RESET;
         duty_step_ff     <= DUTY_STEP_RESET;
         duty_max_ff      <= DUTY_MAX_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_STARTUP_STEPS: startup_steps_ff <= csr_wdata;
            CSR_DUTY_STEP:     duty_step_ff     <= csr_wdata;
            CSR_DUTY_MAX:      duty_max_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: take a beat whenever the held one leaves or none is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_command_ff    <= command_type'(req_command);
         in_host_byte_ff  <= req_host_byte;
         in_sense_line_ff <= req_sense_line;
         in_capture_ff    <= req_capture_value;
      end
   end

   // Event handling: next state from the held beat and the current state.
   always_comb begin
      step_in         = step_ff;
      running_in      = running_ff;
      direction_in    = direction_ff;
      started_in      = started_ff;
      startup_left_in = startup_left_ff;
      duty_in         = duty_ff;
      prev_capture_in = prev_capture_ff;
      period_in       = period_ff;
      drive_in        = drive_ff;

      duty_wide = SUM_WIDTH'(duty_ff);
      step_wide = SUM_WIDTH'(duty_step_ff);
      max_wide  = SUM_WIDTH'(duty_max_ff);
      duty_sum  = duty_wide + step_wide;
      left_dec  = (startup_left_ff != '0) ? startup_left_ff - CSR_WIDTH'(1) : startup_left_ff;

      case (in_command_ff)
         CMD_HOST: begin
            case (in_host_byte_ff)
               HOST_STOP: begin
                  // stop keeps the direction
                  running_in      = 1'b0;
                  started_in      = 1'b0;
                  startup_left_in = '0;
                  drive_in        = STEP_OFF;
               end
               HOST_RUN_CW, HOST_RUN_CCW: begin
                  // ignore a start while already running
                  if (!running_ff) begin
                     running_in      = 1'b1;
                     direction_in    = (in_host_byte_ff == HOST_RUN_CW) ? DIR_CW : DIR_CCW;
                     drive_in        = STEP_OFF;
                     startup_left_in = startup_steps_ff;
                     started_in      = (startup_steps_ff == '0);
                  end
               end
               HOST_DUTY_UP: begin
                  // saturate at duty_max, even when already above it
                  if (duty_sum > max_wide) begin
                     duty_in = DUTY_WIDTH'(max_wide);
                  end else begin
                     duty_in = DUTY_WIDTH'(duty_sum);
                  end
               end
               HOST_DUTY_DOWN: begin
                  if (duty_wide >= step_wide) begin
                     duty_in = DUTY_WIDTH'(duty_wide - step_wide);
                  end else begin
                     duty_in = '0;
                  end
               end
               default: ;
            endcase
         end
         CMD_EDGE: begin
            if (running_ff && started_ff &&
                in_sense_line_ff inside {[SENSE_FIRST:SENSE_LAST]}) begin
               step_in = next_step(step_ff);
            end
         end
         CMD_TICK: begin
            // open loop: drive the current step, then advance
            if (running_ff && !started_ff) begin
               drive_in        = step_ff;
               step_in         = next_step(step_ff);
               startup_left_in = left_dec;
               if (left_dec == '0) begin
                  started_in = 1'b1;
               end
            end
         end
         CMD_CAPTURE: begin
            // hold the period when two captures are equal
            if (in_capture_ff > prev_capture_ff) begin
               period_in = PERIOD_WIDTH'(in_capture_ff) - PERIOD_WIDTH'(prev_capture_ff);
            end else if (in_capture_ff < prev_capture_ff) begin
               period_in = CAP_MASK + PERIOD_WIDTH'(in_capture_ff)
                           - PERIOD_WIDTH'(prev_capture_ff);
            end
            prev_capture_in = in_capture_ff;
         end
         default: ;
      endcase

      // closed loop: drive follows the step
      if (running_in && started_in) begin
         drive_in = step_in;
      end
   end

   ssc_drive_decode u_drive_decode (
      .drive     (drive_in),
      .direction (direction_in),
      .phase     (phase)
   );

   // State registers advance with each beat that leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= STEP_FIRST;
         running_ff      <= 1'b0;
         direction_ff    <= DIR_NONE;
         started_ff      <= 1'b0;
         startup_left_ff <= '0;
         duty_ff         <= DUTY_WIDTH'(DUTY_RESET);
         prev_capture_ff <= '0;
         period_ff       <= '0;
         drive_ff        <= STEP_OFF;
      end else if (advance) begin
         step_ff         <= step_in;
         running_ff      <= running_in;
         direction_ff    <= direction_in;
         started_ff      <= started_in;
         startup_left_ff <= startup_left_in;
         duty_ff         <= duty_in;
         prev_capture_ff <= prev_capture_in;
         period_ff       <= period_in;
         drive_ff        <= drive_in;
      end
   end

   // Result register: hold while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_phase_ff   <= phase;
         out_duty_ff    <= duty_in;
         out_step_ff    <= step_in;
         out_running_ff <= running_in;
         out_started_ff <= started_in;
         out_period_ff  <= period_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_high_a_on   = out_phase_ff.high_on[0];
   assign rsp_high_b_on   = out_phase_ff.high_on[1];
   assign rsp_high_c_on   = out_phase_ff.high_on[2];
   assign rsp_low_a_level = out_phase_ff.low_level[0];
   assign rsp_low_b_level = out_phase_ff.low_level[1];
   assign rsp_low_c_level = out_phase_ff.low_level[2];
   assign rsp_duty_out    = out_duty_ff;
   assign rsp_step_out    = out_step_ff;
   assign rsp_running_out = out_running_ff;
   assign rsp_started_out = out_started_ff;
   assign rsp_period_out  = out_period_ff;

`ifndef SYNTHESIS
   // started is only ever set while running
   assert property (@(posedge clock) disable iff (reset) started_ff |-> running_ff)
      else $error("started set while motor stopped");

   // the step counter stays within one to six
   assert property (@(posedge clock) disable iff (reset)
                    step_ff != STEP_OFF && step_ff != STEP_MIRROR)
      else $error("commutation step out of range");

   // in closed loop the drive tracks the step
   assert property (@(posedge clock) disable iff (reset)
                    (running_ff && started_ff) |-> drive_ff == step_ff)
      else $error("drive does not follow step in closed loop");

   // a pending startup count means open loop while running
   assert property (@(posedge clock) disable iff (reset)
                    (startup_left_ff != '0) |-> (running_ff && !started_ff))
      else $error("startup count left outside open-loop startup");

   // a stalled result beat keeps the state from moving on under it twice
   assert property (@(posedge clock) disable iff (reset)
                    (out_valid_ff && !rsp_ready && in_valid_ff) |=> $stable(step_ff))
      else $error("state advanced while result stalled");
`endif

endmodule
